[sv/rdrt_pkg.sv]
// Types and codes shared by the region dirty-range tracker.
// Depends on nothing; every other file imports it.
package rdrt_pkg;

    typedef enum logic [3:0] {
        MODE_DEFINE      = 4'd0,
        MODE_UPDATE      = 4'd1,
        MODE_UPDATE_ALL  = 4'd2,
        MODE_REALLOC     = 4'd3,
        MODE_REALLOC_ALL = 4'd4,
        MODE_BLIT        = 4'd5,
        MODE_BLIT_ALL    = 4'd6,
        MODE_RENDER      = 4'd7,
        MODE_RENDER_ALL  = 4'd8,
        MODE_LOCK        = 4'd9,
        MODE_PRELOAD     = 4'd10,
        MODE_SET_PHASE   = 4'd11,
        MODE_QUERY       = 4'd12
    } mode_t;

    localparam logic [2:0] PH_REALLOC = 3'd0;
    localparam logic [2:0] PH_BLIT    = 3'd1;
    localparam logic [2:0] PH_RENDER  = 3'd2;
    localparam logic [2:0] PH_SYNC    = 3'd3;
    localparam logic [2:0] PH_NOTSYNC = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SW_RD,
        ST_SW_WR,
        ST_FIN_RD
    } state_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [31:0] first;
        logic [31:0] last;
        logic [31:0] end_byte;
        logic [31:0] reallocs;
        logic        locked;
        logic        preloaded;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

[sv/rdrt_entry_mem.sv]
// Region entry store: one write port, one read port with registered data.
// Depends on rdrt_pkg for the entry record.
module rdrt_entry_mem
    import rdrt_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
)
(
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data
);

    entry_t ram [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ram[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= ram[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/rdrt_entry_upd.sv]
// Entry modify logic: applies one operation to a region record.
// Depends on rdrt_pkg for modes, phase codes and the entry record.
module rdrt_entry_upd
    import rdrt_pkg::*;
(
    input  mode_t       op,
    input  logic        cur_valid,
    input  entry_t      cur,
    input  logic [31:0] start_byte,
    input  logic [31:0] last_byte,
    input  logic [31:0] region_end_byte,
    input  logic        flag_value,
    input  logic [2:0]  new_phase,
    output entry_t      nxt,
    output logic        realloc_inc
);

    logic [31:0] eff_last;

    always_comb
    begin
        nxt         = cur;
        realloc_inc = 1'b0;
        eff_last    = (last_byte == 32'd0) ? cur.end_byte : last_byte;
        unique case (op)
            MODE_DEFINE:
            begin
                if (!cur_valid)
                begin
                    nxt.phase     = PH_REALLOC;
                    nxt.first     = 32'd0;
                    nxt.last      = 32'd0;
                    nxt.reallocs  = 32'd0;
                    nxt.locked    = 1'b0;
                    nxt.preloaded = 1'b0;
                end
                else if (cur.phase != PH_REALLOC)
                begin
                    nxt.phase     = PH_REALLOC;
                    nxt.reallocs  = cur.reallocs + 32'd1;
                    nxt.locked    = 1'b0;
                    nxt.preloaded = 1'b0;
                    realloc_inc   = 1'b1;
                end
                nxt.end_byte = region_end_byte;
            end
            MODE_UPDATE:
            begin
                if (cur.phase == PH_SYNC)
                begin
                    nxt.phase = PH_NOTSYNC;
                    nxt.first = start_byte;
                    nxt.last  = eff_last;
                end
                else if (cur.phase == PH_NOTSYNC)
                begin
                    if (cur.first > start_byte)
                    begin
                        nxt.first = start_byte;
                    end
                    if (cur.last < eff_last)
                    begin
                        nxt.last = eff_last;
                    end
                end
            end
            MODE_REALLOC:
            begin
                if (cur.phase != PH_REALLOC)
                begin
                    nxt.phase    = PH_REALLOC;
                    nxt.reallocs = cur.reallocs + 32'd1;
                    nxt.locked   = 1'b0;
                    realloc_inc  = 1'b1;
                end
            end
            MODE_BLIT:      nxt.phase     = PH_BLIT;
            MODE_RENDER:    nxt.phase     = PH_RENDER;
            MODE_LOCK:      nxt.locked    = flag_value;
            MODE_PRELOAD:   nxt.preloaded = flag_value;
            MODE_SET_PHASE:
            begin
                if (new_phase <= PH_NOTSYNC)
                begin
                    nxt.phase = new_phase;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

[sv/region_dirty_range_tracker.sv]
// Region dirty-range tracker top level: sequencer, valid bits, global count.
// Depends on rdrt_pkg, rdrt_entry_mem and rdrt_entry_upd.
//
//   channel   handshake        payload
//   command   start / busy     mode, region_index, start_byte, last_byte,
//                              region_end_byte, flag_value, new_phase
//   result    done (1 cycle)   error, phase, range_first, range_last,
//                              region_realloc_count, locked, preloaded,
//                              total_realloc_count
//
// Single-region word: read at accept, modify and write back next cycle,
// result strobed in the cycle after; busy holds off a new word until the write-back is done.
// All-region word: a sweep over the entry store, reading each entry (ST_SW_RD) and
// writing back the valid ones (ST_SW_WR), then a read of the addressed entry (ST_FIN_RD) and the result.
// Reset clears the valid bits and the global count; no clearing pass.
// The receiver cannot stall; busy holds off commands while a word is in work.
module region_dirty_range_tracker
    import rdrt_pkg::*;
#(
    parameter int REGIONS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  mode,
    input  logic [3:0]  region_index,
    input  logic [31:0] start_byte,
    input  logic [31:0] last_byte,
    input  logic [31:0] region_end_byte,
    input  logic        flag_value,
    input  logic [2:0]  new_phase,
    output logic        done,
    output logic        error,
    output logic [2:0]  phase,
    output logic [31:0] range_first,
    output logic [31:0] range_last,
    output logic [31:0] region_realloc_count,
    output logic        locked,
    output logic        preloaded,
    output logic [31:0] total_realloc_count
);

    localparam int IW = (REGIONS > 1) ? $clog2(REGIONS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(REGIONS - 1);

    state_t            state_reg, state_next;
    mode_t             mode_reg, mode_next;
    logic              all_reg, all_next;
    logic              inr_reg, inr_next;
    logic [IW-1:0]     addr_reg, addr_next;
    logic [31:0]       sb_reg, sb_next;
    logic [31:0]       lb_reg, lb_next;
    logic [31:0]       eb_reg, eb_next;
    logic              fv_reg, fv_next;
    logic [2:0]        np_reg, np_next;
    logic [IW-1:0]     cnt_reg, cnt_next;
    logic [REGIONS-1:0] valid_reg, valid_next;
    logic [31:0]       global_reg, global_next;
    logic              done_reg, done_next;
    logic              error_reg, error_next;
    entry_t            res_reg, res_next;

    logic              accept;
    mode_t             in_mode;
    logic              in_all;
    logic              mem_rd_en;
    logic [IW-1:0]     mem_rd_addr;
    entry_t            mem_rd_data;
    logic              mem_wr_en;
    logic [IW-1:0]     mem_wr_addr;
    mode_t             upd_op;
    logic              upd_valid;
    logic [31:0]       upd_sb;
    logic [31:0]       upd_lb;
    entry_t            upd_nxt;
    logic              upd_inc;
    logic              ok;

    assign accept  = start && !busy;
    assign busy    = (state_reg != ST_IDLE);
    assign in_mode = mode_t'(mode);
    assign in_all  = (in_mode == MODE_UPDATE_ALL) || (in_mode == MODE_REALLOC_ALL) ||
                     (in_mode == MODE_BLIT_ALL) || (in_mode == MODE_RENDER_ALL);
    assign ok      = inr_reg && valid_reg[addr_reg];

    rdrt_entry_mem #(
        .DEPTH (REGIONS),
        .AW    (IW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (upd_nxt)
    );

    rdrt_entry_upd u_upd (
        .op              (upd_op),
        .cur_valid       (upd_valid),
        .cur             (mem_rd_data),
        .start_byte      (upd_sb),
        .last_byte       (upd_lb),
        .region_end_byte (eb_reg),
        .flag_value      (fv_reg),
        .new_phase       (np_reg),
        .nxt             (upd_nxt),
        .realloc_inc     (upd_inc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            valid_reg  <= '0;
            global_reg <= 32'd0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            global_reg <= global_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        all_reg   <= all_next;
        inr_reg   <= inr_next;
        addr_reg  <= addr_next;
        sb_reg    <= sb_next;
        lb_reg    <= lb_next;
        eb_reg    <= eb_next;
        fv_reg    <= fv_next;
        np_reg    <= np_next;
        error_reg <= error_next;
        res_reg   <= res_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        all_next    = all_reg;
        inr_next    = inr_reg;
        addr_next   = addr_reg;
        sb_next     = sb_reg;
        lb_next     = lb_reg;
        eb_next     = eb_reg;
        fv_next     = fv_reg;
        np_next     = np_reg;
        cnt_next    = cnt_reg;
        valid_next  = valid_reg;
        global_next = global_reg;
        done_next   = 1'b0;
        error_next  = error_reg;
        res_next    = res_reg;
        mem_rd_en   = 1'b0;
        mem_rd_addr = addr_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = addr_reg;
        upd_op      = MODE_QUERY;
        upd_valid   = 1'b1;
        upd_sb      = sb_reg;
        upd_lb      = lb_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                mem_rd_addr = IW'(region_index);
                if (accept)
                begin
                    mem_rd_en  = 1'b1;
                    mode_next  = in_mode;
                    all_next   = in_all;
                    inr_next   = (32'(region_index) < 32'(REGIONS));
                    addr_next  = IW'(region_index);
                    sb_next    = start_byte;
                    lb_next    = last_byte;
                    eb_next    = region_end_byte;
                    fv_next    = flag_value;
                    np_next    = new_phase;
                    cnt_next   = '0;
                    state_next = in_all ? ST_SW_RD : ST_EXEC;
                end
            end
            ST_SW_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = cnt_reg;
                state_next  = ST_SW_WR;
            end
            ST_SW_WR:
            begin
                unique case (mode_reg)
                    MODE_UPDATE_ALL:  upd_op = MODE_UPDATE;
                    MODE_REALLOC_ALL: upd_op = MODE_REALLOC;
                    MODE_BLIT_ALL:    upd_op = MODE_BLIT;
                    MODE_RENDER_ALL:  upd_op = MODE_RENDER;
                    default:          upd_op = MODE_QUERY;
                endcase
                upd_sb      = 32'd0;
                upd_lb      = 32'd0;
                mem_wr_addr = cnt_reg;
                mem_wr_en   = valid_reg[cnt_reg];
                global_next = global_reg + {31'd0, upd_inc && valid_reg[cnt_reg]};
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = ST_FIN_RD;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_SW_RD;
                end
            end
            ST_FIN_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = addr_reg;
                state_next  = ST_EXEC;
            end
            ST_EXEC:
            begin
                upd_op    = all_reg ? MODE_QUERY : mode_reg;
                upd_valid = valid_reg[addr_reg];
                if (!all_reg && (mode_reg == MODE_DEFINE))
                begin
                    mem_wr_en = inr_reg;
                    if (inr_reg)
                    begin
                        valid_next[addr_reg] = 1'b1;
                    end
                    error_next = !inr_reg;
                end
                else
                begin
                    mem_wr_en  = ok;
                    error_next = !ok;
                end
                global_next = global_reg + {31'd0, upd_inc && mem_wr_en};
                res_next    = error_next ? '0 : upd_nxt;
                done_next   = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign done                 = done_reg;
    assign error                = error_reg;
    assign phase                = res_reg.phase;
    assign range_first          = res_reg.first;
    assign range_last           = res_reg.last;
    assign region_realloc_count = res_reg.reallocs;
    assign locked               = res_reg.locked;
    assign preloaded            = res_reg.preloaded;
    assign total_realloc_count  = global_reg;

`ifndef SYNTHESIS
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_EXEC))
        else $error("result strobe without a finished word");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && error) |-> (phase == 3'd0 && range_first == 32'd0 &&
                             range_last == 32'd0 && region_realloc_count == 32'd0 &&
                             !locked && !preloaded))
        else $error("error result carries entry fields");

    a_global_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(global_reg) |->
            ($past(state_reg == ST_EXEC || state_reg == ST_SW_WR) &&
             global_reg == $past(global_reg) + 32'd1))
        else $error("global realloc count moved outside a write-back");

    a_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |-> (($past(valid_reg) & ~valid_reg) == '0))
        else $error("region valid bit dropped");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted without going busy");
`endif

endmodule
